// ----- rtl/ratree_pkg.sv -----
// Shared constants for the range-add global-max segment tree.
package ratree_pkg;

    localparam int LEAVES      = 1024;
    localparam int TREE_LEAVES = 1 << $clog2(LEAVES);
    localparam int TREE_NODES  = 2 * TREE_LEAVES;
    localparam int NODE_W      = $clog2(TREE_NODES);
    localparam int IDX_W       = 11;
    localparam int DELTA_W     = 16;
    localparam int DATA_W      = 32;

endpackage

// ----- rtl/ratree_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ratree_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/range_add_global_max_tree.sv -----
// Top level: segment tree with range add and global maximum, one shared RAM sequencer.
//
// Input channel: range_lo, range_hi, delta with in_valid / in_stall. A
// transaction is taken when in_valid is high and in_stall is low. Each
// transaction adds delta to leaves [range_lo, range_hi) (bounds saturate at
// 1024; an empty range changes nothing) and yields one transaction on the
// output channel: max_value with out_valid / out_stall, the maximum over all
// 1024 leaves after the update.
// One item is handled at a time. Every node access goes through the single
// read port of the max and pending RAMs: an add reads a node and then writes
// its pending value, a re-derive reads both children and then writes the
// larger child sum as the node's maximum, and a level check touches no RAM.
// out_valid rises in the same cycle as in_stall drops. The result sits in an
// output register; the next transaction is taken while it waits. If the
// previous result is still stalled when a new one is ready, the sequencer
// holds until it is taken.
// After reset a clearing pass writes zero to all 2048 nodes; in_stall stays
// high during it.
module range_add_global_max_tree (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [ratree_pkg::IDX_W-1:0]           range_lo,
    input  logic [ratree_pkg::IDX_W-1:0]           range_hi,
    input  logic signed [ratree_pkg::DELTA_W-1:0]  delta,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [ratree_pkg::DATA_W-1:0]   max_value
);

    localparam int NW = ratree_pkg::NODE_W;
    localparam int DW = ratree_pkg::DATA_W;

    typedef enum logic [9:0] {
        ST_CLEAR     = 10'b0000000001,
        ST_IDLE      = 10'b0000000010,
        ST_PLAN      = 10'b0000000100,
        ST_ADD_RD    = 10'b0000001000,
        ST_ADD_WR    = 10'b0000010000,
        ST_DER_RL    = 10'b0000100000,
        ST_DER_RR    = 10'b0001000000,
        ST_DER_WR    = 10'b0010000000,
        ST_ROOT_RD   = 10'b0100000000,
        ST_ROOT_WAIT = 10'b1000000000
    } state_t;

    typedef enum logic [7:0] {
        PH_ADD_L   = 8'b00000001,
        PH_ADD_R   = 8'b00000010,
        PH_CHECK   = 8'b00000100,
        PH_ADD_LP1 = 8'b00001000,
        PH_ADD_RM1 = 8'b00010000,
        PH_DER_L   = 8'b00100000,
        PH_DER_R   = 8'b01000000,
        PH_CLIMB   = 8'b10000000
    } phase_t;

    state_t                          state_reg, state_next;
    phase_t                          phase_reg, phase_next;
    logic [NW-1:0]                   l_reg, l_next;
    logic [NW-1:0]                   r_reg, r_next;
    logic [NW-1:0]                   op_reg, op_next;
    logic [NW-1:0]                   clr_reg, clr_next;
    logic signed [DW-1:0]            d_reg, d_next;
    logic signed [DW-1:0]            a_reg, a_next;
    logic                            out_valid_reg, out_valid_next;
    logic signed [DW-1:0]            out_reg, out_next;

    logic                            max_we, pend_we;
    logic [NW-1:0]                   wr_addr, rd_addr;
    logic [DW-1:0]                   max_wd, pend_wd;
    logic [DW-1:0]                   max_rd, pend_rd;
    logic signed [DW-1:0]            node_sum;
    logic [ratree_pkg::IDX_W-1:0]    lo_c, hi_c;
    logic                            accept;

    ratree_ram #(.WIDTH(DW), .DEPTH(ratree_pkg::TREE_NODES)) u_max_ram (
        .clk     (clk),
        .wr_en   (max_we),
        .wr_addr (wr_addr),
        .wr_data (max_wd),
        .rd_addr (rd_addr),
        .rd_data (max_rd)
    );

    ratree_ram #(.WIDTH(DW), .DEPTH(ratree_pkg::TREE_NODES)) u_pend_ram (
        .clk     (clk),
        .wr_en   (pend_we),
        .wr_addr (wr_addr),
        .wr_data (pend_wd),
        .rd_addr (rd_addr),
        .rd_data (pend_rd)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign max_value = out_reg;
    assign node_sum  = $signed(max_rd + pend_rd);

    assign lo_c = (range_lo > ratree_pkg::IDX_W'(ratree_pkg::LEAVES))
                  ? ratree_pkg::IDX_W'(ratree_pkg::LEAVES) : range_lo;
    assign hi_c = (range_hi > ratree_pkg::IDX_W'(ratree_pkg::LEAVES))
                  ? ratree_pkg::IDX_W'(ratree_pkg::LEAVES) : range_hi;

    always_comb
    begin
        max_we  = 1'b0;
        pend_we = 1'b0;
        wr_addr = op_reg;
        rd_addr = op_reg;
        max_wd  = '0;
        pend_wd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                max_we  = 1'b1;
                pend_we = 1'b1;
                wr_addr = clr_reg;
            end
            ST_ADD_WR:
            begin
                pend_we = 1'b1;
                pend_wd = pend_rd + d_reg;
            end
            ST_DER_RL:
            begin
                rd_addr = {op_reg[NW-2:0], 1'b0};
            end
            ST_DER_RR:
            begin
                rd_addr = {op_reg[NW-2:0], 1'b1};
            end
            ST_DER_WR:
            begin
                max_we = 1'b1;
                max_wd = (a_reg > node_sum) ? a_reg : node_sum;
            end
            ST_ROOT_RD, ST_ROOT_WAIT:
            begin
                rd_addr = NW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        op_next        = op_reg;
        clr_next       = clr_reg;
        d_next         = d_reg;
        a_next         = a_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + NW'(1);
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    d_next     = DW'(delta);
                    l_next     = NW'(lo_c) + NW'(ratree_pkg::TREE_LEAVES);
                    r_next     = NW'(hi_c) - NW'(1) + NW'(ratree_pkg::TREE_LEAVES);
                    phase_next = PH_ADD_L;
                    state_next = (lo_c < hi_c) ? ST_PLAN : ST_ROOT_RD;
                end
            end
            ST_PLAN:
            begin
                case (phase_reg)
                    PH_ADD_L:
                    begin
                        op_next    = l_reg;
                        state_next = ST_ADD_RD;
                        phase_next = PH_ADD_R;
                    end
                    PH_ADD_R:
                    begin
                        op_next    = r_reg;
                        phase_next = PH_CHECK;
                        if (l_reg != r_reg)
                        begin
                            state_next = ST_ADD_RD;
                        end
                    end
                    PH_CHECK:
                    begin
                        if ((l_reg >> 1) != (r_reg >> 1))
                        begin
                            phase_next = PH_ADD_LP1;
                        end
                        else
                        begin
                            l_next     = l_reg >> 1;
                            phase_next = PH_CLIMB;
                        end
                    end
                    PH_ADD_LP1:
                    begin
                        op_next    = l_reg + NW'(1);
                        phase_next = PH_ADD_RM1;
                        if (!l_reg[0])
                        begin
                            state_next = ST_ADD_RD;
                        end
                    end
                    PH_ADD_RM1:
                    begin
                        op_next    = r_reg - NW'(1);
                        l_next     = l_reg >> 1;
                        r_next     = r_reg >> 1;
                        phase_next = PH_DER_L;
                        if (r_reg[0])
                        begin
                            state_next = ST_ADD_RD;
                        end
                    end
                    PH_DER_L:
                    begin
                        op_next    = l_reg;
                        phase_next = PH_DER_R;
                        state_next = ST_DER_RL;
                    end
                    PH_DER_R:
                    begin
                        op_next    = r_reg;
                        phase_next = PH_CHECK;
                        state_next = ST_DER_RL;
                    end
                    PH_CLIMB:
                    begin
                        if (l_reg != '0)
                        begin
                            op_next    = l_reg;
                            l_next     = l_reg >> 1;
                            state_next = ST_DER_RL;
                        end
                        else
                        begin
                            state_next = ST_ROOT_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_ROOT_RD;
                    end
                endcase
            end
            ST_ADD_RD:
            begin
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                state_next = ST_PLAN;
            end
            ST_DER_RL:
            begin
                state_next = ST_DER_RR;
            end
            ST_DER_RR:
            begin
                a_next     = node_sum;
                state_next = ST_DER_WR;
            end
            ST_DER_WR:
            begin
                state_next = ST_PLAN;
            end
            ST_ROOT_RD:
            begin
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    out_next       = node_sum;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_ADD_L;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        op_reg  <= op_next;
        d_reg   <= d_next;
        a_reg   <= a_next;
        out_reg <= out_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input taken while an item is in progress");

    a_derive_internal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DER_RL) |->
            (op_reg != '0) && (op_reg < NW'(ratree_pkg::TREE_LEAVES)))
        else $error("re-derive on a leaf or node zero");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_ROOT_WAIT))
        else $error("result raised outside root read");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg && in_stall)
        else $error("activity during clearing pass");

endmodule
